/* rtl/core/ook_rpd_pkg.sv */
// Package for the OOK remote pulse decoder.
// Holds register indexes, reset values and the types shared between modules.
// No dependencies.
package ook_rpd_pkg;

  localparam int unsigned LEN_W  = 8;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned RAW_W  = 12;
  localparam int unsigned NIB_W  = 4;

  localparam logic [IDX_W-1:0] REG_SHORT_NOMINAL = 8'd0;
  localparam logic [IDX_W-1:0] REG_LONG_NOMINAL  = 8'd1;
  localparam logic [IDX_W-1:0] REG_TOLERANCE     = 8'd2;
  localparam logic [IDX_W-1:0] REG_GAP_LIMIT     = 8'd3;

  localparam logic [LEN_W-1:0] RST_SHORT_NOMINAL = 8'd22;
  localparam logic [LEN_W-1:0] RST_LONG_NOMINAL  = 8'd66;
  localparam logic [LEN_W-1:0] RST_TOLERANCE     = 8'd10;
  localparam logic [LEN_W-1:0] RST_GAP_LIMIT     = 8'd100;

  typedef struct packed {
    logic [LEN_W-1:0] short_nominal;
    logic [LEN_W-1:0] long_nominal;
    logic [LEN_W-1:0] tolerance;
    logic [LEN_W-1:0] gap_limit;
  } cfg_t;

  typedef struct packed {
    logic [NIB_W-1:0] house_index;
    logic [NIB_W-1:0] unit_number;
    logic             command_on;
    logic [RAW_W-1:0] raw_code;
  } res_t;

  typedef struct packed {
    logic load;
    res_t res;
  } res_req_t;

endpackage

/* rtl/core/ook_rpd_pulse_if.sv */
// Input channel of the OOK remote pulse decoder: one received pulse per request.
// Depends on ook_rpd_pkg for field widths.
interface ook_rpd_pulse_if;
  logic                           valid;
  logic                           ready;
  logic                           level;
  logic [ook_rpd_pkg::LEN_W-1:0]  pulse_length;

  modport source (output valid, output level, output pulse_length, input ready);
  modport sink   (input valid, input level, input pulse_length, output ready);
endinterface

/* rtl/core/ook_rpd_code_if.sv */
// Output channel of the OOK remote pulse decoder: one decoded code per request.
// Depends on ook_rpd_pkg for field widths.
interface ook_rpd_code_if;
  logic                           valid;
  logic                           ready;
  logic [ook_rpd_pkg::NIB_W-1:0]  house_index;
  logic [ook_rpd_pkg::NIB_W-1:0]  unit_number;
  logic                           command_on;
  logic [ook_rpd_pkg::RAW_W-1:0]  raw_code;

  modport source (output valid, output house_index, output unit_number,
                  output command_on, output raw_code, input ready);
  modport sink   (input valid, input house_index, input unit_number,
                  input command_on, input raw_code, output ready);
endinterface

/* rtl/core/ook_rpd_cfg_if.sv */
// Configuration write channel of the OOK remote pulse decoder.
// Depends on ook_rpd_pkg for field widths.
interface ook_rpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ook_rpd_pkg::IDX_W-1:0]  index;
  logic [ook_rpd_pkg::LEN_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ook_rpd_cfg.sv */
// Configuration register file of the OOK remote pulse decoder.
// Depends on ook_rpd_pkg and ook_rpd_cfg_if.
module ook_rpd_cfg (
  input  logic               clk,
  input  logic               rst,
  ook_rpd_cfg_if.sink        cfg,
  output ook_rpd_pkg::cfg_t  regs
);
  import ook_rpd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_nominal <= RST_SHORT_NOMINAL;
      regs.long_nominal  <= RST_LONG_NOMINAL;
      regs.tolerance     <= RST_TOLERANCE;
      regs.gap_limit     <= RST_GAP_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SHORT_NOMINAL: regs.short_nominal <= cfg.data;
        REG_LONG_NOMINAL:  regs.long_nominal  <= cfg.data;
        REG_TOLERANCE:     regs.tolerance     <= cfg.data;
        REG_GAP_LIMIT:     regs.gap_limit     <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/ook_rpd_dec.sv */
// Pulse classifier and symbol sequencer of the OOK remote pulse decoder.
// Registers the input pulse, then updates phase, shift register and symbol count.
// Depends on ook_rpd_pkg and ook_rpd_pulse_if.
module ook_rpd_dec #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  ook_rpd_pulse_if.sink          pulse,
  input  ook_rpd_pkg::cfg_t      regs,
  input  logic                   out_busy,
  output ook_rpd_pkg::res_req_t  req
);
  import ook_rpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_BITS + 2);
  localparam int unsigned EXT_W = (CODE_BITS > RAW_W) ? CODE_BITS : RAW_W;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(CODE_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_BITS - 1);

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_INVALID = 6'b000010,
    PH_S       = 6'b000100,
    PH_SL      = 6'b001000,
    PH_SLS     = 6'b010000,
    PH_SLL     = 6'b100000
  } phase_t;

  logic                  in_vld;
  logic                  in_level;
  logic [LEN_W-1:0]      in_len;
  phase_t                phase, phase_next;
  logic [CODE_BITS-1:0]  code_shift, code_shift_next;
  logic [CNT_W-1:0]      symbol_count, symbol_count_next;
  logic                  gap, is_s, is_l, add, add_bit, emit, advance;
  logic [EXT_W-1:0]      code_ext;

  assign advance     = in_vld && !(emit && out_busy);
  assign pulse.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (pulse.ready) begin
      in_vld <= pulse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse.ready && pulse.valid) begin
      in_level <= pulse.level;
      in_len   <= pulse.pulse_length;
    end
  end

  assign gap  = in_len > regs.gap_limit;
  assign is_s = ({1'b0, in_len} + {1'b0, regs.tolerance} > {1'b0, regs.short_nominal}) &&
                ({1'b0, in_len} < {1'b0, regs.short_nominal} + {1'b0, regs.tolerance});
  assign is_l = ({1'b0, in_len} + {1'b0, regs.tolerance} > {1'b0, regs.long_nominal}) &&
                ({1'b0, in_len} < {1'b0, regs.long_nominal} + {1'b0, regs.tolerance});

  always_comb begin
    phase_next        = phase;
    symbol_count_next = symbol_count;
    add               = 1'b0;
    add_bit           = 1'b0;
    if (gap) begin
      phase_next        = PH_IDLE;
      symbol_count_next = '0;
    end else begin
      unique case (phase)
        PH_INVALID: begin
          symbol_count_next = '0;
          phase_next = (in_level && is_s) ? PH_S : PH_INVALID;
        end
        PH_IDLE: begin
          phase_next = (in_level && is_s) ? PH_S : PH_INVALID;
        end
        PH_S: begin
          phase_next = (!in_level && is_l) ? PH_SL : PH_INVALID;
        end
        PH_SL: begin
          if (in_level && is_l) phase_next = PH_SLL;
          else if (in_level && is_s) phase_next = PH_SLS;
          else phase_next = PH_INVALID;
        end
        PH_SLS: begin
          add = !in_level && is_l;
          phase_next = add ? PH_IDLE : PH_INVALID;
        end
        PH_SLL: begin
          add     = !in_level && is_s;
          add_bit = 1'b1;
          phase_next = add ? PH_IDLE : PH_INVALID;
        end
        default: begin
          phase_next = PH_INVALID;
        end
      endcase
    end
    code_shift_next = add ? {add_bit, code_shift[CODE_BITS-1:1]} : code_shift;
    if (add && symbol_count < CNT_MAX) begin
      symbol_count_next = symbol_count + 1'b1;
    end
  end

  assign emit     = add && (symbol_count == CNT_LAST);
  assign code_ext = EXT_W'(code_shift_next);

  assign req.load            = advance && emit;
  assign req.res.house_index = code_ext[NIB_W-1:0];
  assign req.res.unit_number = code_ext[2*NIB_W-1:NIB_W] + 1'b1;
  assign req.res.command_on  = code_shift_next[CODE_BITS-1];
  assign req.res.raw_code    = code_ext[RAW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      code_shift   <= '0;
      symbol_count <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      code_shift   <= code_shift_next;
      symbol_count <= symbol_count_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    symbol_count <= CNT_MAX)
    else $error("symbol count beyond saturation");

  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    req.load |-> (phase == PH_SLS || phase == PH_SLL))
    else $error("result emitted outside a symbol end");

  a_gap_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && gap) |=> (symbol_count == '0 && phase == PH_IDLE))
    else $error("gap pulse did not reset the decoder");
`endif

endmodule

/* rtl/core/ook_rpd_out.sv */
// Output register of the OOK remote pulse decoder.
// Holds one decoded code until the sink takes it. Depends on ook_rpd_pkg, ook_rpd_code_if.
module ook_rpd_out (
  input  logic                   clk,
  input  logic                   rst,
  input  ook_rpd_pkg::res_req_t  req,
  output logic                   out_busy,
  ook_rpd_code_if.source         code
);
  import ook_rpd_pkg::*;

  logic vld;
  res_t res;

  assign out_busy = vld && !code.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (req.load) begin
      vld <= 1'b1;
    end else if (code.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      res <= req.res;
    end
  end

  assign code.valid       = vld;
  assign code.house_index = res.house_index;
  assign code.unit_number = res.unit_number;
  assign code.command_on  = res.command_on;
  assign code.raw_code    = res.raw_code;

endmodule

/* rtl/core/ook_remote_pulse_decoder_top.sv */
// A pulse request is registered in the input register, and the code that it completes is
// registered in the output register. Throughput: one pulse per cycle; the input stalls only
// when a new code is due while the previous one is still held for the sink.
// Reset (rst, synchronous) restores default timing registers, clears phase, shift
// register and symbol count, and empties the input and output registers.
// Depends on ook_rpd_pkg, the channel interfaces and ook_rpd_cfg, ook_rpd_dec, ook_rpd_out.
module ook_remote_pulse_decoder_top #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  ook_rpd_pulse_if.sink    pulse,
  ook_rpd_code_if.source   code,
  ook_rpd_cfg_if.sink      cfg
);
  import ook_rpd_pkg::*;

  cfg_t     regs;
  res_req_t req;
  logic     out_busy;

  ook_rpd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ook_rpd_dec #(
    .CODE_BITS (CODE_BITS)
  ) u_dec (
    .clk      (clk),
    .rst      (rst),
    .pulse    (pulse),
    .regs     (regs),
    .out_busy (out_busy),
    .req      (req)
  );

  ook_rpd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .out_busy (out_busy),
    .code     (code)
  );

endmodule
